// File: design/u8dw_pkg.sv
// ----------------------------------------------------------------------------
// u8dw_pkg
// Shared types, constants and classification functions for the UTF-8
// decoder with display width.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dw_pkg;

  localparam int TOTAL_WIDTH_BITS = 16;
  localparam int CP_BITS          = 21;
  localparam int USED_BITS        = 3;
  localparam int COLS_BITS        = 2;
  localparam int GROUP_SLOTS      = 4;
  localparam int SLOT_BITS        = $clog2(GROUP_SLOTS);
  localparam int COUNT_BITS       = $clog2(GROUP_SLOTS + 1);
  localparam int QUEUE_DEPTH      = 4;
  localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] LEAD_MASK   = 8'hC0;
  localparam logic [7:0] CONT_MARK   = 8'h80;
  localparam logic [7:0] PAIR_MASK   = 8'hFE;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_MARK  = 8'hE0;
  localparam logic [7:0] LEAD_LIMIT  = 8'hF8;

  localparam logic [CP_BITS-1:0] CP_ZWJ = 21'h0200D;

  localparam logic [USED_BITS-1:0] LEN_NONE = 3'd0;
  localparam logic [USED_BITS-1:0] LEN_ONE  = 3'd1;
  localparam logic [USED_BITS-1:0] LEN_TWO  = 3'd2;
  localparam logic [USED_BITS-1:0] LEN_THREE = 3'd3;
  localparam logic [USED_BITS-1:0] LEN_FOUR = 3'd4;

  localparam logic [COLS_BITS-1:0] COLS_ZERO = 2'd0;
  localparam logic [COLS_BITS-1:0] COLS_ONE  = 2'd1;
  localparam logic [COLS_BITS-1:0] COLS_TWO  = 2'd2;

  // results caused by one request, oldest in slot 0
  typedef struct packed {
    logic [COUNT_BITS-1:0]                    count;
    logic                                     eot;
    logic [GROUP_SLOTS-1:0][CP_BITS-1:0]      cp;
    logic [GROUP_SLOTS-1:0][USED_BITS-1:0]    used;
  } cp_group_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & LEAD_MASK) == CONT_MARK;
  endfunction

  function automatic logic in_range(input logic [CP_BITS-1:0] cp,
                                    input logic [CP_BITS-1:0] lo,
                                    input logic [CP_BITS-1:0] hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  function automatic logic is_combining_cp(input logic [CP_BITS-1:0] cp);
    return (cp == CP_ZWJ) ||
           in_range(cp, 21'h00300, 21'h0036F) ||
           in_range(cp, 21'h01AB0, 21'h01AFF) ||
           in_range(cp, 21'h01DC0, 21'h01DFF) ||
           in_range(cp, 21'h020D0, 21'h020FF) ||
           in_range(cp, 21'h0FE20, 21'h0FE2F);
  endfunction

  function automatic logic is_wide_cp(input logic [CP_BITS-1:0] cp);
    return in_range(cp, 21'h01100, 21'h0115F) ||
           in_range(cp, 21'h02E80, 21'h0A4CF) ||
           in_range(cp, 21'h0AC00, 21'h0D7A3) ||
           in_range(cp, 21'h0F900, 21'h0FAFF) ||
           in_range(cp, 21'h0FE10, 21'h0FE19) ||
           in_range(cp, 21'h0FE30, 21'h0FE6F) ||
           in_range(cp, 21'h0FF00, 21'h0FF60) ||
           in_range(cp, 21'h0FFE0, 21'h0FFE6) ||
           in_range(cp, 21'h1F300, 21'h1FAFF);
  endfunction

  function automatic logic [COLS_BITS-1:0] char_cols(input logic [CP_BITS-1:0] cp);
    logic [COLS_BITS-1:0] cols;
    if ((cp < 21'h00020) || in_range(cp, 21'h0007F, 21'h0009F)) begin
      cols = COLS_ZERO;
    end else if (is_combining_cp(cp)) begin
      cols = COLS_ZERO;
    end else if (is_wide_cp(cp)) begin
      cols = COLS_TWO;
    end else begin
      cols = COLS_ONE;
    end
    return cols;
  endfunction

endpackage

`default_nettype wire

// File: design/u8dw_front.sv
// ----------------------------------------------------------------------------
// u8dw_front
// Takes text bytes, tracks the partial sequence and turns each request into
// a group of up to four code points for the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dw_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_valid,
  output logic                       byte_ready,
  input  wire logic [7:0]            text_byte,
  input  wire logic                  end_of_text,
  input  wire logic                  q_full,
  output logic                       q_push,
  output u8dw_pkg::cp_group_t        q_data
);
  import u8dw_pkg::*;

  logic [2:0][7:0]        held_bytes;
  logic [2:0][7:0]        held_bytes_next;
  logic [1:0]             held_count;
  logic [1:0]             held_count_next;
  logic [USED_BITS-1:0]   expected_length;
  logic [USED_BITS-1:0]   expected_length_next;
  cp_group_t              grp;
  logic                   accept;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign q_push     = accept && (grp.count != '0);
  assign q_data     = grp;

  always_comb begin
    logic [2:0][7:0]       hb;
    logic [1:0]            cnt;
    logic [USED_BITS-1:0]  exp_len;
    logic                  lead;
    logic [COUNT_BITS-1:0] n;
    logic [CP_BITS-1:0]    cp;
    hb      = held_bytes;
    cnt     = held_count;
    exp_len = expected_length;
    lead    = 1'b1;
    n       = '0;
    grp     = '0;
    cp      = '0;

    if (cnt != 2'd0) begin
      if (is_cont(text_byte)) begin
        lead = 1'b0;
        if (({1'b0, cnt} + 3'd1) >= exp_len) begin
          if (exp_len == LEN_TWO) begin
            cp = {10'd0, hb[0][4:0], text_byte[5:0]};
          end else if (exp_len == LEN_THREE) begin
            cp = {5'd0, hb[0][3:0], hb[1][5:0], text_byte[5:0]};
          end else begin
            cp = {hb[0][2:0], hb[1][5:0], hb[2][5:0], text_byte[5:0]};
          end
          grp.cp[n[SLOT_BITS-1:0]]   = cp;
          grp.used[n[SLOT_BITS-1:0]] = exp_len;
          n       = n + 1'b1;
          cnt     = 2'd0;
          exp_len = LEN_NONE;
        end else begin
          hb[cnt] = text_byte;
          cnt     = cnt + 2'd1;
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < cnt) begin
            grp.cp[n[SLOT_BITS-1:0]]   = {13'd0, hb[i]};
            grp.used[n[SLOT_BITS-1:0]] = LEN_ONE;
            n = n + 1'b1;
          end
        end
        cnt     = 2'd0;
        exp_len = LEN_NONE;
      end
    end

    if (lead) begin
      if (!text_byte[7] || is_cont(text_byte) ||
          ((text_byte & PAIR_MASK) == LEAD_MASK) || (text_byte >= LEAD_LIMIT)) begin
        grp.cp[n[SLOT_BITS-1:0]]   = {13'd0, text_byte};
        grp.used[n[SLOT_BITS-1:0]] = LEN_ONE;
        n = n + 1'b1;
      end else begin
        if ((text_byte & LEAD2_MASK) == LEAD_MASK) begin
          exp_len = LEN_TWO;
        end else if ((text_byte & LEAD3_MASK) == LEAD3_MARK) begin
          exp_len = LEN_THREE;
        end else begin
          exp_len = LEN_FOUR;
        end
        hb[0] = text_byte;
        cnt   = 2'd1;
      end
    end

    if (end_of_text && (cnt != 2'd0)) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cnt) begin
          grp.cp[n[SLOT_BITS-1:0]]   = {13'd0, hb[i]};
          grp.used[n[SLOT_BITS-1:0]] = LEN_ONE;
          n = n + 1'b1;
        end
      end
      cnt     = 2'd0;
      exp_len = LEN_NONE;
    end

    grp.count            = n;
    grp.eot              = end_of_text;
    held_bytes_next      = hb;
    held_count_next      = cnt;
    expected_length_next = exp_len;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= held_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      expected_length <= LEN_NONE;
    end else if (accept) begin
      held_count      <= held_count_next;
      expected_length <= expected_length_next;
    end
  end

endmodule

`default_nettype wire

// File: design/u8dw_queue.sv
// ----------------------------------------------------------------------------
// u8dw_queue
// Short first-in first-out queue of code point groups between the byte side
// and the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dw_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire u8dw_pkg::cp_group_t   push_data,
  input  wire logic                  pop,
  output u8dw_pkg::cp_group_t        head,
  output logic                       full,
  output logic                       empty
);
  import u8dw_pkg::*;

  cp_group_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] fill;

  assign full  = (fill == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/u8dw_back.sv
// ----------------------------------------------------------------------------
// u8dw_back
// Walks each code point group one result per cycle while not stalled,
// looks up display width and combining flag, keeps saturating running total.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dw_back (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire u8dw_pkg::cp_group_t                    head,
  input  wire logic                                   q_empty,
  output logic                                        q_pop,
  output logic                                        result_valid,
  input  wire logic                                   result_ready,
  output logic [u8dw_pkg::CP_BITS-1:0]                code_point,
  output logic [u8dw_pkg::USED_BITS-1:0]              bytes_used,
  output logic [u8dw_pkg::COLS_BITS-1:0]              char_width,
  output logic                                        is_combining,
  output logic [u8dw_pkg::TOTAL_WIDTH_BITS-1:0]       total_width,
  output logic                                        last_of_run,
  output logic                                        text_done
);
  import u8dw_pkg::*;

  logic [SLOT_BITS-1:0]        slot;
  logic [TOTAL_WIDTH_BITS-1:0] width_sum;
  logic [TOTAL_WIDTH_BITS-1:0] width_sum_next;
  logic [TOTAL_WIDTH_BITS:0]   sum_wide;
  logic                        load;
  logic                        last;
  logic [CP_BITS-1:0]          cur_cp;
  logic [COLS_BITS-1:0]        cur_cols;

  assign load     = !q_empty && (!result_valid || result_ready);
  assign cur_cp   = head.cp[slot];
  assign cur_cols = char_cols(cur_cp);
  assign last     = ({1'b0, slot} + 1'b1) == head.count;
  assign q_pop    = load && last;
  assign sum_wide = {1'b0, width_sum} + (TOTAL_WIDTH_BITS + 1)'(cur_cols);
  assign width_sum_next = sum_wide[TOTAL_WIDTH_BITS] ? '1 :
                          sum_wide[TOTAL_WIDTH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      slot         <= '0;
      width_sum    <= '0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        slot         <= last ? '0 : slot + 1'b1;
        width_sum    <= (last && head.eot) ? '0 : width_sum_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point   <= cur_cp;
      bytes_used   <= head.used[slot];
      char_width   <= cur_cols;
      is_combining <= is_combining_cp(cur_cp);
      total_width  <= width_sum_next;
      last_of_run  <= last;
      text_done    <= last && head.eot;
    end
  end

endmodule

`default_nettype wire

// File: design/utf8_decode_display_width_top.sv
// ----------------------------------------------------------------------------
// utf8_decode_display_width_top
// UTF-8 decoder that reports each code point with its display width.
//
// Byte channel: byte_valid/byte_ready carry text_byte and end_of_text, one
// request per cycle while byte_ready is high. Result channel:
// result_valid/result_ready carry one code point with bytes_used, char_width,
// is_combining, total_width, last_of_run and text_done.
// A request causes zero to four results, queued as one group that leaves
// through the output register one result per cycle while result_ready is
// high, so a byte causing several results occupies the result side until
// all are taken. Bytes are taken one per cycle as long as the four-group
// queue has room; plain text (one result per byte) streams at one byte per
// cycle while result_ready is high. When the receiver stalls, results wait
// in the output register and the queue fills; byte_ready drops only when
// the queue is full. Reset drops any partial sequence, empties the queue
// and clears the running total.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decode_display_width_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   byte_valid,
  output logic                                        byte_ready,
  input  wire logic [7:0]                             text_byte,
  input  wire logic                                   end_of_text,
  output logic                                        result_valid,
  input  wire logic                                   result_ready,
  output logic [u8dw_pkg::CP_BITS-1:0]                code_point,
  output logic [u8dw_pkg::USED_BITS-1:0]              bytes_used,
  output logic [u8dw_pkg::COLS_BITS-1:0]              char_width,
  output logic                                        is_combining,
  output logic [u8dw_pkg::TOTAL_WIDTH_BITS-1:0]       total_width,
  output logic                                        last_of_run,
  output logic                                        text_done
);
  import u8dw_pkg::*;

  cp_group_t push_data;
  cp_group_t head;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  u8dw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .q_full      (full),
    .q_push      (push),
    .q_data      (push_data)
  );

  u8dw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  u8dw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (empty),
    .q_pop        (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .code_point   (code_point),
    .bytes_used   (bytes_used),
    .char_width   (char_width),
    .is_combining (is_combining),
    .total_width  (total_width),
    .last_of_run  (last_of_run),
    .text_done    (text_done)
  );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 decoder with display width. Directed
// texts and random texts (mostly well-formed sequences with broken and
// noisy ones mixed in) go through the byte channel under random idling on
// both sides. Every result is scored field by field against a decoder model
// that advances on each accepted request.
// ----------------------------------------------------------------------------
module tb_top;
  import u8dw_pkg::*;

  localparam int TW           = TOTAL_WIDTH_BITS;
  localparam int RAND_ITEMS   = 76;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 100;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
    logic [1:0] phase;
    logic       pause;
    logic       hold;
  } text_req_t;

  typedef struct packed {
    logic [CP_BITS-1:0]   cp;
    logic [USED_BITS-1:0] used;
    logic [COLS_BITS-1:0] cols;
    logic                 mark;
    logic [TW-1:0]        total;
    logic                 last;
    logic                 done;
  } glyph_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_ready;
  logic [7:0]           text_byte = 8'h00;
  logic                 end_of_text = 1'b0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [CP_BITS-1:0]   code_point;
  logic [USED_BITS-1:0] bytes_used;
  logic [COLS_BITS-1:0] char_width;
  logic                 is_combining;
  logic [TW-1:0]        total_width;
  logic                 last_of_run;
  logic                 text_done;

  utf8_decode_display_width_top u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .code_point   (code_point),
    .bytes_used   (bytes_used),
    .char_width   (char_width),
    .is_combining (is_combining),
    .total_width  (total_width),
    .last_of_run  (last_of_run),
    .text_done    (text_done)
  );

  always #1 clk = ~clk;

  text_req_t req_q[$];
  glyph_t    glyph_q[$];
  logic [7:0] line_q[$];

  logic [7:0]           held_b [3] = '{8'h00, 8'h00, 8'h00};
  int                   held_n = 0;
  logic [USED_BITS-1:0] want_len = LEN_NONE;
  logic [TW-1:0]        col_sum = '0;
  glyph_t               run_buf [4];
  int                   run_n;

  int         err_cnt = 0;
  bit         byte_took = 1'b0;
  bit         rx_hold_req = 1'b0;
  int         rx_hold_left = 0;
  logic [1:0] cur_phase = 2'd0;
  logic [1:0] gen_phase = 2'd0;
  logic       gen_pause = 1'b0;
  logic       gen_hold = 1'b0;
  int         tx_idle_pct [3] = '{27, 51, 0};
  int         rx_idle_pct [3] = '{51, 27, 0};

  logic [CP_BITS-1:0] border_cps [34] = '{
    21'h0001F, 21'h00020, 21'h0007E, 21'h0009F, 21'h000A0, 21'h00300,
    21'h0036F, 21'h01100, 21'h0115F, 21'h01AB0, 21'h01AFF, 21'h01DC0,
    21'h01DFF, 21'h0200D, 21'h020D0, 21'h020FF, 21'h02E80, 21'h0A4CF,
    21'h0AC00, 21'h0D7A3, 21'h0F900, 21'h0FAFF, 21'h0FE10, 21'h0FE19,
    21'h0FE20, 21'h0FE2F, 21'h0FE30, 21'h0FE6F, 21'h0FF00, 21'h0FF60,
    21'h0FFE0, 21'h0FFE6, 21'h1F300, 21'h1FAFF
  };

  function automatic logic span(input logic [CP_BITS-1:0] c, input int lo, input int hi);
    return (int'(c) >= lo) && (int'(c) <= hi);
  endfunction

  function automatic logic mark_cp(input logic [CP_BITS-1:0] c);
    return (c == CP_ZWJ) || span(c, 'h300, 'h36F) || span(c, 'h1AB0, 'h1AFF) ||
           span(c, 'h1DC0, 'h1DFF) || span(c, 'h20D0, 'h20FF) ||
           span(c, 'hFE20, 'hFE2F);
  endfunction

  function automatic logic [COLS_BITS-1:0] cols_for(input logic [CP_BITS-1:0] c);
    if (span(c, 0, 'h1F) || span(c, 'h7F, 'h9F) || mark_cp(c)) begin
      return COLS_ZERO;
    end
    if (span(c, 'h1100, 'h115F) || span(c, 'h2E80, 'hA4CF) || span(c, 'hAC00, 'hD7A3) ||
        span(c, 'hF900, 'hFAFF) || span(c, 'hFE10, 'hFE19) || span(c, 'hFE30, 'hFE6F) ||
        span(c, 'hFF00, 'hFF60) || span(c, 'hFFE0, 'hFFE6) ||
        span(c, 'h1F300, 'h1FAFF)) begin
      return COLS_TWO;
    end
    return COLS_ONE;
  endfunction

  function automatic logic [7:0] rand_byte(input int lo, input int hi);
    logic [31:0] r;
    r = $urandom_range(hi, lo);
    return r[7:0];
  endfunction

  task automatic add_glyph(input logic [CP_BITS-1:0] c, input logic [USED_BITS-1:0] u);
    logic [TW:0] s;
    glyph_t      g;
    g.cp   = c;
    g.used = u;
    g.cols = cols_for(c);
    g.mark = mark_cp(c);
    s = {1'b0, col_sum} + {{(TW - 1){1'b0}}, g.cols};
    col_sum = s[TW] ? {TW{1'b1}} : s[TW-1:0];
    g.total = col_sum;
    g.last  = 1'b0;
    g.done  = 1'b0;
    run_buf[run_n] = g;
    run_n++;
  endtask

  task automatic release_held();
    for (int i = 0; i < held_n; i++) begin
      add_glyph({13'b0, held_b[i]}, LEN_ONE);
    end
    held_n   = 0;
    want_len = LEN_NONE;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic               lead;
    logic [CP_BITS-1:0] c;
    logic [5:0]         h1;
    logic [5:0]         h2;
    run_n = 0;
    lead  = 1'b1;
    if (held_n > 0) begin
      if ((b & LEAD_MASK) == CONT_MARK) begin
        lead = 1'b0;
        if (held_n + 1 >= want_len) begin
          h1 = held_b[1][5:0];
          h2 = held_b[2][5:0];
          case (want_len)
            LEN_TWO: c = {10'b0, held_b[0][4:0], b[5:0]};
            LEN_THREE: c = {5'b0, held_b[0][3:0], h1, b[5:0]};
            default: c = {held_b[0][2:0], h1, h2, b[5:0]};
          endcase
          add_glyph(c, want_len);
          held_n   = 0;
          want_len = LEN_NONE;
        end else begin
          held_b[held_n] = b;
          held_n++;
        end
      end else begin
        release_held();
      end
    end
    if (lead) begin
      if (!b[7] || (b & LEAD_MASK) == CONT_MARK || (b & PAIR_MASK) == LEAD_MASK ||
          b >= LEAD_LIMIT) begin
        add_glyph({13'b0, b}, LEN_ONE);
      end else begin
        if ((b & LEAD2_MASK) == LEAD_MASK) begin
          want_len = LEN_TWO;
        end else if ((b & LEAD3_MASK) == LEAD3_MARK) begin
          want_len = LEN_THREE;
        end else begin
          want_len = LEN_FOUR;
        end
        held_b[0] = b;
        held_n    = 1;
      end
    end
    if (eot && held_n > 0) begin
      release_held();
    end
    if (run_n > 0) begin
      run_buf[run_n-1].last = 1'b1;
      if (eot) begin
        run_buf[run_n-1].done = 1'b1;
        col_sum = '0;
      end
    end
    for (int i = 0; i < run_n; i++) begin
      glyph_q.push_back(run_buf[i]);
    end
  endtask

  task automatic put_cp(input logic [CP_BITS-1:0] c);
    if (c < 21'h80) begin
      line_q.push_back(c[7:0]);
    end else if (c < 21'h800) begin
      line_q.push_back({3'b110, c[10:6]});
      line_q.push_back({2'b10, c[5:0]});
    end else if (c < 21'h10000) begin
      line_q.push_back({4'b1110, c[15:12]});
      line_q.push_back({2'b10, c[11:6]});
      line_q.push_back({2'b10, c[5:0]});
    end else begin
      line_q.push_back({5'b11110, c[20:18]});
      line_q.push_back({2'b10, c[17:12]});
      line_q.push_back({2'b10, c[11:6]});
      line_q.push_back({2'b10, c[5:0]});
    end
  endtask

  // lead of the given length followed by some continuation bytes
  task automatic put_partial(input int len, input int conts);
    logic [7:0] ld;
    case (len)
      2: ld = LEAD_MASK | rand_byte(2, 31);
      3: ld = LEAD3_MARK | rand_byte(0, 15);
      default: ld = LEAD3_MASK | rand_byte(0, 7);
    endcase
    line_q.push_back(ld);
    repeat (conts) line_q.push_back(CONT_MARK | rand_byte(0, 63));
  endtask

  task automatic commit_text();
    text_req_t r;
    while (line_q.size() > 0) begin
      r.b     = line_q.pop_front();
      r.eot   = (line_q.size() == 0);
      r.phase = gen_phase;
      r.pause = gen_pause;
      r.hold  = gen_hold;
      gen_pause = 1'b0;
      gen_hold  = 1'b0;
      req_q.push_back(r);
    end
  endtask

  task automatic gen_text();
    int         n_ch;
    int         kind;
    int         len;
    int         pick;
    logic [7:0] brk;
    n_ch = $urandom_range(6, 1);
    repeat (n_ch) begin
      kind = $urandom_range(99, 0);
      len  = $urandom_range(4, 2);
      if (kind < 20) begin
        line_q.push_back(rand_byte(0, 127));
      end else if (kind < 40) begin
        pick = $urandom_range(33, 0);
        put_cp(CP_BITS'(border_cps[pick] + $urandom_range(2, 0) - 1));
      end else if (kind < 70) begin
        put_partial(len, len - 1);
      end else if (kind < 82) begin
        put_partial(len, $urandom_range(len - 2, 0));
        do begin
          brk = rand_byte(0, 255);
        end while ((brk & LEAD_MASK) == CONT_MARK);
        line_q.push_back(brk);
      end else if (kind < 90) begin
        line_q.push_back(rand_byte(0, 255));
      end else begin
        pick = $urandom_range(2, 0);
        case (pick)
          0: line_q.push_back(rand_byte('h80, 'hBF));
          1: line_q.push_back(rand_byte('hC0, 'hC1));
          default: line_q.push_back(rand_byte('hF8, 'hFF));
        endcase
      end
    end
    // cut off inside a sequence at end of text
    if ($urandom_range(3, 0) == 0) begin
      len = $urandom_range(4, 2);
      put_partial(len, $urandom_range(len - 2, 0));
    end
    commit_text();
  endtask

  // request driver
  always @(negedge clk) begin
    text_req_t nxt;
    if (!rst && (!byte_valid || byte_took)) begin
      byte_took = 1'b0;
      if (req_q.size() == 0 || (req_q[0].pause && glyph_q.size() != 0) ||
          $urandom_range(99, 0) < tx_idle_pct[cur_phase]) begin
        byte_valid <= 1'b0;
      end else begin
        nxt = req_q.pop_front();
        cur_phase = nxt.phase;
        if (nxt.hold) begin
          rx_hold_req = 1'b1;
        end
        byte_valid  <= 1'b1;
        text_byte   <= nxt.b;
        end_of_text <= nxt.eot;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (rx_hold_req) begin
        rx_hold_req  = 1'b0;
        rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99, 0) >= rx_idle_pct[cur_phase]);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      if (err_cnt < MAX_REPORTS) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      end
      err_cnt++;
    end
  endtask

  // result monitor and request capture
  always @(posedge clk) begin
    glyph_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (glyph_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS) begin
            $display("%0t: code_point expected none actual %0h", $time, code_point);
          end
          err_cnt++;
        end else begin
          want = glyph_q.pop_front();
          check_field("code_point", 32'(want.cp), 32'(code_point));
          check_field("bytes_used", 32'(want.used), 32'(bytes_used));
          check_field("char_width", 32'(want.cols), 32'(char_width));
          check_field("is_combining", 32'(want.mark), 32'(is_combining));
          check_field("total_width", 32'(want.total), 32'(total_width));
          check_field("last_of_run", 32'(want.last), 32'(last_of_run));
          check_field("text_done", 32'(want.done), 32'(text_done));
        end
      end
      if (byte_valid && byte_ready) begin
        decode_byte(text_byte, end_of_text);
        byte_took = 1'b1;
      end
    end
  end

  initial begin
    int base;
    int made;
    // controls, a plain letter, stray continuation, never-lead bytes
    line_q = '{8'h00, 8'h7F, 8'h41, 8'h80, 8'hC0, 8'hC1, 8'hF8, 8'hFF};
    commit_text();
    // two, three and four byte forms, broken sequence, top code point,
    // end of text inside a sequence
    line_q = '{8'hC3, 8'hA9, 8'hE2, 8'h80, 8'h8D, 8'hF0, 8'h9F, 8'h98, 8'h80,
               8'hE4, 8'h41, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hE4, 8'hB8};
    commit_text();

    base = req_q.size();
    while (req_q.size() - base < RAND_ITEMS) begin
      made = req_q.size() - base;
      if (made < RAND_ITEMS / 3) begin
        gen_phase = 2'd0;
      end else if (made < 2 * RAND_ITEMS / 3) begin
        if (gen_phase == 2'd0) begin
          gen_pause = 1'b1;
        end
        gen_phase = 2'd1;
      end else begin
        if (gen_phase == 2'd1) begin
          gen_hold = 1'b1;
        end
        gen_phase = 2'd2;
      end
      gen_text();
    end

    gen_phase = 2'd2;
    gen_text();

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (req_q.size() != 0 || byte_valid) @(posedge clk);
    while (glyph_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && glyph_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
design/u8dw_pkg.sv
design/u8dw_front.sv
design/u8dw_queue.sv
design/u8dw_back.sv
design/utf8_decode_display_width_top.sv
verif/tb_top.sv
